// ===== hdl/twdp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twdp_pkg
// Shared widths, weight codes and types for the ternary-weight dot product.
// ----------------------------------------------------------------------------
package twdp_pkg;

  localparam int ACT_COUNT = 4;   // activations per group
  localparam int COL_LANES = 4;   // output columns handled side by side
  localparam int ACT_W     = 8;
  localparam int CODE_W    = 2;
  localparam int WBYTE_W   = ACT_COUNT * CODE_W;
  localparam int ACC_W     = 32;
  // one group adds at most four terms of magnitude up to 128
  localparam int CONTRIB_W = ACT_W + 3;

  typedef enum logic [CODE_W-1:0] {
    CODE_ZERO = 2'b00,
    CODE_POS  = 2'b01,
    CODE_NEG  = 2'b10,
    CODE_NIL  = 2'b11
  } wcode_t;

  typedef logic [ACT_COUNT-1:0][ACT_W-1:0] act_vec_t;
  typedef logic [COL_LANES-1:0][ACC_W-1:0] sum_vec_t;

  // per-transfer control seen by every lane and by the merge stage
  typedef struct packed {
    logic accept;
    logic last;
  } twdp_ctl_t;

endpackage

// ===== hdl/twdp_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twdp_lane
// One column: decodes four ternary codes, sums the signed group contribution
// and folds it into the column accumulator.
// ----------------------------------------------------------------------------
module twdp_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  twdp_pkg::twdp_ctl_t           ctl,
  input  twdp_pkg::act_vec_t            act,
  input  logic [twdp_pkg::WBYTE_W-1:0]  wbyte,
  output logic [twdp_pkg::ACC_W-1:0]    acc_sum
);

  logic [twdp_pkg::CONTRIB_W-1:0] contrib;
  logic [twdp_pkg::ACC_W-1:0]     acc_r;
  logic [twdp_pkg::ACC_W-1:0]     acc_nxt;

  always_comb begin
    logic [twdp_pkg::CONTRIB_W-1:0] term;
    twdp_pkg::wcode_t               code;
    contrib = '0;
    for (int p = 0; p < twdp_pkg::ACT_COUNT; p++) begin
      term = {{(twdp_pkg::CONTRIB_W - twdp_pkg::ACT_W){act[p][twdp_pkg::ACT_W-1]}},
              act[p]};
      code = twdp_pkg::wcode_t'(wbyte[p*twdp_pkg::CODE_W +: twdp_pkg::CODE_W]);
      case (code)
        twdp_pkg::CODE_POS: contrib = contrib + term;
        twdp_pkg::CODE_NEG: contrib = contrib - term;
        default: ;
      endcase
    end
  end

  // running sum including the current group; wraps modulo 2^32
  assign acc_sum = acc_r +
    {{(twdp_pkg::ACC_W - twdp_pkg::CONTRIB_W){contrib[twdp_pkg::CONTRIB_W-1]}}, contrib};

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.accept) begin
      acc_nxt = ctl.last ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== hdl/twdp_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twdp_merge
// Gathers the lane sums of a last-group transfer into the output register
// and holds them until the result transfer completes.
// ----------------------------------------------------------------------------
module twdp_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  twdp_pkg::twdp_ctl_t  ctl,
  input  twdp_pkg::sum_vec_t   lane_sum,
  input  logic                 out_stall,
  output logic                 out_valid,
  output twdp_pkg::sum_vec_t   out_sum,
  output logic                 busy
);

  logic               valid_r;
  logic               valid_nxt;
  twdp_pkg::sum_vec_t sum_r;
  logic               load;

  assign load = ctl.accept & ctl.last;
  // a held result that is not being taken blocks the next transfer
  assign busy = valid_r & out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= lane_sum;
    end
  end

  assign out_valid = valid_r;
  assign out_sum   = sum_r;

endmodule

// ===== hdl/ternary_weight_dot_product.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_weight_dot_product
// A last-group transfer shows its four sums in the cycle after it is accepted.
// Throughput: one input transfer per cycle; the input stalls only while a
// finished result waits downstream.
// Reset (rst_n low, synchronous): accumulators clear, no result pending.
// ----------------------------------------------------------------------------
// Four column lanes decode their packed 2-bit ternary codes and add or
// subtract the four int8 activations into a 32-bit wrapping accumulator.
// On the transfer marked last the group is folded in, the lane totals go to
// the output register in the merge stage and the accumulators clear, so the
// next row can start in the very next cycle unless a held result is stalled.
// ----------------------------------------------------------------------------
module ternary_weight_dot_product (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [7:0]  in_act_0,
  input  logic signed [7:0]  in_act_1,
  input  logic signed [7:0]  in_act_2,
  input  logic signed [7:0]  in_act_3,
  input  logic [7:0]         in_wbyte_col0,
  input  logic [7:0]         in_wbyte_col1,
  input  logic [7:0]         in_wbyte_col2,
  input  logic [7:0]         in_wbyte_col3,
  input  logic               in_last_group,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_sum_col0,
  output logic signed [31:0] out_sum_col1,
  output logic signed [31:0] out_sum_col2,
  output logic signed [31:0] out_sum_col3
);

  twdp_pkg::twdp_ctl_t ctl;
  twdp_pkg::act_vec_t  act;
  twdp_pkg::sum_vec_t  lane_sum;
  twdp_pkg::sum_vec_t  out_sum;
  logic [twdp_pkg::COL_LANES-1:0][twdp_pkg::WBYTE_W-1:0] wbyte;
  logic                busy;

  // activations are shared by every lane
  assign act[0] = in_act_0;
  assign act[1] = in_act_1;
  assign act[2] = in_act_2;
  assign act[3] = in_act_3;

  assign wbyte[0] = in_wbyte_col0;
  assign wbyte[1] = in_wbyte_col1;
  assign wbyte[2] = in_wbyte_col2;
  assign wbyte[3] = in_wbyte_col3;

  // input transfer happens when in_valid is high and the output register can take a result
  assign in_stall   = busy;
  assign ctl.accept = in_valid & ~busy;
  assign ctl.last   = in_last_group;

  for (genvar c = 0; c < twdp_pkg::COL_LANES; c++) begin : g_lane
    twdp_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .act     (act),
      .wbyte   (wbyte[c]),
      .acc_sum (lane_sum[c])
    );
  end

  // output register / merge of the lane totals
  twdp_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .lane_sum  (lane_sum),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_sum   (out_sum),
    .busy      (busy)
  );

  assign out_sum_col0 = out_sum[0];
  assign out_sum_col1 = out_sum[1];
  assign out_sum_col2 = out_sum[2];
  assign out_sum_col3 = out_sum[3];

endmodule
